[rtl/gbts_pkg.sv]
// Shared types and constants of the gap-buffer text store.
// Used by gbts_ctrl, gbts_datapath and gap_buffer_text_store; depends on nothing.
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 13;
    localparam int CHAR_W   = 8;

    localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        KIND_FINISH,
        KIND_INS_HERE,
        KIND_MOVE,
        KIND_READ
    } item_kind_t;

    typedef struct packed {
        logic load;
        logic finish;
        logic insert;
        logic move;
        logic read_issue;
        logic read_done;
    } dp_cmd_t;

    typedef struct packed {
        item_kind_t kind;
        logic       gap_at_pos;
    } dp_stat_t;

endpackage

[rtl/gbts_ctrl.sv]
// Controller state machine of the gap-buffer text store.
// Depends on gbts_pkg; drives the datapath through dp_cmd_t and reads dp_stat_t.
module gbts_ctrl
    import gbts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOVE,
        S_INS,
        S_RD
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.kind)
                    KIND_FINISH:
                    begin
                        if (out_free)
                        begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_INS_HERE:
                    begin
                        if (out_free)
                        begin
                            cmd.insert = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    KIND_MOVE:
                    begin
                        state_next = S_MOVE;
                    end
                    KIND_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_RD;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_MOVE:
            begin
                // The last copy write lands in the cycle the gap reaches the position.
                cmd.move = 1'b1;
                if (stat.gap_at_pos)
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                if (out_free)
                begin
                    cmd.insert = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                if (out_free)
                begin
                    cmd.read_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.finish || cmd.insert || cmd.read_done)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

`ifndef SYNTH
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.finish, cmd.insert, cmd.read_done}))
        else $error("more than one result produced in a cycle");

    a_result_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !(cmd.finish || cmd.insert || cmd.read_done))
        else $error("result overwrote a waiting transfer");

    a_read_follow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.read_issue |=> (state_reg == S_RD))
        else $error("read issued without collecting its data");
`endif

endmodule

[rtl/gbts_datapath.sv]
// Datapath of the gap-buffer text store: item registers, gap pointers, text memory,
// pipelined gap-move copy and result registers. Depends on gbts_pkg.
module gbts_datapath
    import gbts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_cmd_t           cmd,
    input  logic [1:0]        action,
    input  logic [POS_W-1:0]  text_position,
    input  logic [CHAR_W-1:0] char_in,
    output dp_stat_t          stat,
    output logic [CHAR_W-1:0] char_out,
    output logic [POS_W-1:0]  text_length,
    output logic [1:0]        status
);

    logic [CHAR_W-1:0] text_mem [CAPACITY];

    logic [1:0]        action_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [CHAR_W-1:0] ch_reg;

    logic [POS_W-1:0]  gap_first_reg, gap_first_next;
    logic [POS_W-1:0]  gap_after_reg, gap_after_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [CHAR_W-1:0] rdata_reg;

    logic [CHAR_W-1:0] char_out_reg;
    logic [POS_W-1:0]  length_reg;
    logic [1:0]        status_reg;

    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  rd_map;
    logic [1:0]        res_status;
    item_kind_t        kind;
    logic              gap_at_pos;
    logic              move_left;
    logic              step;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;

    assign len        = gap_first_reg + (CAP_POS - gap_after_reg);
    assign gap_at_pos = (pos_reg == gap_first_reg);
    assign move_left  = (pos_reg < gap_first_reg);
    assign rd_map     = move_left ? pos_reg : pos_reg + (gap_after_reg - gap_first_reg);
    assign step       = cmd.move && !gap_at_pos;

    always_comb
    begin
        res_status = ST_OK;
        kind       = KIND_FINISH;
        case (action_reg)
            ACT_INSERT:
            begin
                if (len >= CAP_POS)
                begin
                    res_status = ST_FULL;
                end
                else if (pos_reg > len)
                begin
                    res_status = ST_RANGE;
                end
                else if (gap_at_pos)
                begin
                    kind = KIND_INS_HERE;
                end
                else
                begin
                    kind = KIND_MOVE;
                end
            end
            ACT_READ:
            begin
                if (pos_reg >= len)
                begin
                    res_status = ST_RANGE;
                end
                else
                begin
                    kind = KIND_READ;
                end
            end
            default:
            begin
                kind = KIND_FINISH;
            end
        endcase
    end

    assign stat.kind       = kind;
    assign stat.gap_at_pos = gap_at_pos;

    // Copy across the gap: a byte read in one cycle is written in the next,
    // so one byte moves per cycle. Moving left goes top down, moving right bottom up.
    always_comb
    begin
        gap_first_next = gap_first_reg;
        gap_after_next = gap_after_reg;
        pend_next      = pend_reg;
        wa_next        = wa_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_map[ADDR_W-1:0];
        if (cmd.read_issue)
        begin
            rd_en = 1'b1;
        end
        if (cmd.move)
        begin
            pend_next = step;
        end
        if (step)
        begin
            rd_en = 1'b1;
            if (move_left)
            begin
                rd_addr        = ADDR_W'(gap_first_reg - 1'b1);
                wa_next        = ADDR_W'(gap_after_reg - 1'b1);
                gap_first_next = gap_first_reg - 1'b1;
                gap_after_next = gap_after_reg - 1'b1;
            end
            else
            begin
                rd_addr        = gap_after_reg[ADDR_W-1:0];
                wa_next        = gap_first_reg[ADDR_W-1:0];
                gap_first_next = gap_first_reg + 1'b1;
                gap_after_next = gap_after_reg + 1'b1;
            end
        end
        if (cmd.insert)
        begin
            gap_first_next = gap_first_reg + 1'b1;
        end
        if (cmd.finish && (action_reg == ACT_CLEAR))
        begin
            gap_first_next = '0;
            gap_after_next = CAP_POS;
        end
    end

    assign mem_we    = (cmd.move && pend_reg) || cmd.insert;
    assign mem_waddr = cmd.insert ? gap_first_reg[ADDR_W-1:0] : wa_reg;
    assign mem_wdata = cmd.insert ? ch_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            text_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= text_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_first_reg <= '0;
            gap_after_reg <= CAP_POS;
            pend_reg      <= 1'b0;
        end
        else
        begin
            gap_first_reg <= gap_first_next;
            gap_after_reg <= gap_after_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wa_reg <= wa_next;
        if (cmd.load)
        begin
            action_reg <= action;
            pos_reg    <= text_position;
            ch_reg     <= char_in;
        end
        if (cmd.finish)
        begin
            char_out_reg <= '0;
            status_reg   <= res_status;
            length_reg   <= (action_reg == ACT_CLEAR) ? '0 : len;
        end
        else if (cmd.insert)
        begin
            char_out_reg <= '0;
            status_reg   <= ST_OK;
            length_reg   <= len + 1'b1;
        end
        else if (cmd.read_done)
        begin
            char_out_reg <= rdata_reg;
            status_reg   <= ST_OK;
            length_reg   <= len;
        end
    end

    assign char_out    = char_out_reg;
    assign text_length = length_reg;
    assign status      = status_reg;

`ifndef SYNTH
    a_gap_order: assert property (@(posedge clk) disable iff (!rst_n)
        (gap_first_reg <= gap_after_reg) && (gap_after_reg <= CAP_POS))
        else $error("gap pointers out of order");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> (gap_at_pos && (gap_first_reg != gap_after_reg)))
        else $error("insert without room at the gap");

    a_move_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.move && gap_at_pos) |=> !pend_reg)
        else $error("copy write left pending after the gap move");
`endif

endmodule

[rtl/gap_buffer_text_store.sv]
// Top level of the gap-buffer text store: stream ports, controller and datapath.
// Depends on gbts_pkg, gbts_ctrl and gbts_datapath.
//
// A byte store of 4096 characters kept as a gap buffer. Each input transfer carries one
// action (insert, read or clear) and yields exactly one result transfer with the byte
// read, the text length after the item and a status. An insert at the current gap, a
// clear, a failed item or an unknown action is accepted and then decoded; a read adds
// the registered read of the text memory after the decode. An insert elsewhere first
// moves the gap, copying one byte a cycle through the single-write-port memory, and
// then writes the byte at the insert position. The next item is accepted while a
// result still waits to be taken. No clearing pass is needed after reset.
module gap_buffer_text_store
    import gbts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // text_position[12:0], char_in[20:13], zero [23:21]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // char_out[7:0], text_length[20:8], zero [23:21]
    output logic [1:0]  m_tuser    // status[1:0]
);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  text_length;
    logic [1:0]        status;

    gbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gbts_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (s_tuser),
        .text_position (s_tdata[12:0]),
        .char_in       (s_tdata[20:13]),
        .stat          (stat),
        .char_out      (char_out),
        .text_length   (text_length),
        .status        (status)
    );

    assign m_tdata = {3'b000, text_length, char_out};
    assign m_tuser = status;

endmodule

[test/tb_top.sv]
// Self-checking testbench of the gap-buffer text store: drives edit items, predicts each reply
// from a shadow gap buffer and compares every result transfer field by field.
// Depends on gbts_pkg and gap_buffer_text_store.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gbts_pkg::*;

    localparam logic [1:0] ACT_UNKNOWN = 2'd3;
    localparam int CLK_HALF        = 5;
    localparam int STALL_PERCENT   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int RANDOM_ITEMS    = 1200;
    localparam int POS_MAX         = (1 << POS_W) - 1;

    typedef struct {
        logic [CHAR_W-1:0] char_out;
        logic [POS_W-1:0]  text_length;
        logic [1:0]        status;
    } store_reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    logic idling_on        = 1'b1;
    logic hold_off_request = 1'b0;
    int   hold_left        = 0;
    int   quiet_cycles     = 0;
    int   fail_count       = 0;

    store_reply_t awaited_replies[$];

    // Shadow copy of the store, kept as the same gap buffer.
    logic [CHAR_W-1:0] shadow_text [CAPACITY];
    int                shadow_gap_first;
    int                shadow_gap_after;

    gap_buffer_text_store DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int shadow_length();
        return shadow_gap_first + (CAPACITY - shadow_gap_after);
    endfunction

    function automatic store_reply_t edit_shadow_text(logic [1:0] act, int pos,
                                                      logic [CHAR_W-1:0] ch);
        store_reply_t reply;
        int           len;
        int           delta;
        len = shadow_length();
        reply.char_out = '0;
        reply.status   = ST_OK;
        case (act)
            ACT_INSERT:
            begin
                if (len >= CAPACITY)
                    reply.status = ST_FULL;
                else if (pos > len)
                    reply.status = ST_RANGE;
                else
                begin
                    if (pos < shadow_gap_first)
                    begin
                        // Bytes ahead of the cursor slide up behind the gap; copy from the top
                        // down so that overlapping runs stay intact.
                        delta = shadow_gap_first - pos;
                        for (int i = delta - 1; i >= 0; i--)
                            shadow_text[shadow_gap_after - delta + i] = shadow_text[pos + i];
                        shadow_gap_first -= delta;
                        shadow_gap_after -= delta;
                    end
                    else if (pos > shadow_gap_first)
                    begin
                        delta = pos - shadow_gap_first;
                        for (int i = 0; i < delta; i++)
                            shadow_text[shadow_gap_first + i] = shadow_text[shadow_gap_after + i];
                        shadow_gap_first += delta;
                        shadow_gap_after += delta;
                    end
                    shadow_text[shadow_gap_first] = ch;
                    shadow_gap_first++;
                end
            end
            ACT_READ:
            begin
                if (pos >= len)
                    reply.status = ST_RANGE;
                else if (pos < shadow_gap_first)
                    reply.char_out = shadow_text[pos];
                else
                    reply.char_out = shadow_text[pos + shadow_gap_after - shadow_gap_first];
            end
            ACT_CLEAR:
            begin
                shadow_gap_first = 0;
                shadow_gap_after = CAPACITY;
            end
            default:
            begin
            end
        endcase
        reply.text_length = POS_W'(shadow_length());
        return reply;
    endfunction

    // Offers one item and records its predicted reply once the transfer has taken place.
    task automatic offer_edit(input logic [1:0] act, input int pos, input logic [CHAR_W-1:0] ch);
        store_reply_t predicted;
        while (idling_on && $urandom_range(0, 99) < STALL_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {3'b000, ch, POS_W'(pos)};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted       = edit_shadow_text(act, pos, ch);
        awaited_replies = {awaited_replies, predicted};
    endtask

    // Mostly well-formed editing on a text kept at or below max_len, with some noise mixed in.
    task automatic offer_random_edit(input int max_len);
        int len;
        int roll;
        int pos;
        len  = shadow_length();
        roll = $urandom_range(0, 99);
        if (roll < 2 || len >= max_len)
            offer_edit(ACT_CLEAR, $urandom_range(0, POS_MAX), CHAR_W'($urandom_range(0, 255)));
        else if (roll < 4)
            offer_edit(ACT_UNKNOWN, $urandom_range(0, POS_MAX), CHAR_W'($urandom_range(0, 255)));
        else if (roll < 7)
            offer_edit(ACT_INSERT, $urandom_range(len + 1, POS_MAX),
                       CHAR_W'($urandom_range(0, 255)));
        else if (roll < 10)
            offer_edit(ACT_READ, $urandom_range(len, POS_MAX), CHAR_W'($urandom_range(0, 255)));
        else if (roll < 55 || len == 0)
        begin
            // Half the inserts continue at the cursor, as typing does; the rest jump.
            if ($urandom_range(0, 1) == 1)
                pos = shadow_gap_first;
            else
                pos = $urandom_range(0, len);
            offer_edit(ACT_INSERT, pos, CHAR_W'($urandom_range(0, 255)));
        end
        else
            offer_edit(ACT_READ, $urandom_range(0, len - 1), CHAR_W'($urandom_range(0, 255)));
    endtask

    task automatic test_directed_cases();
        offer_edit(ACT_READ, 0, 8'h00);
        offer_edit(ACT_INSERT, 1, 8'h11);
        offer_edit(ACT_INSERT, 0, 8'h00);
        offer_edit(ACT_INSERT, 1, 8'hFF);
        offer_edit(ACT_INSERT, 0, 8'h55);
        offer_edit(ACT_INSERT, 3, 8'hAA);
        for (int i = 0; i < 4; i++)
            offer_edit(ACT_READ, i, 8'h00);
        offer_edit(ACT_READ, 4, 8'h00);
        offer_edit(ACT_READ, POS_MAX, 8'hFF);
        offer_edit(ACT_INSERT, POS_MAX, 8'hFF);
        offer_edit(ACT_INSERT, 5, 8'h5A);
        offer_edit(ACT_UNKNOWN, POS_MAX, 8'hFF);
        offer_edit(ACT_UNKNOWN, 0, 8'h00);
        offer_edit(ACT_READ, 1, 8'h00);
        offer_edit(ACT_CLEAR, 0, 8'h00);
        offer_edit(ACT_READ, 0, 8'h00);
        offer_edit(ACT_INSERT, 0, 8'h80);
        offer_edit(ACT_READ, 0, 8'h00);
        offer_edit(ACT_CLEAR, POS_MAX, 8'hFF);
    endtask

    task automatic test_random_editing();
        int max_len;
        max_len = 16;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                max_len = $urandom_range(4, 160);
            offer_random_edit(max_len);
        end
    endtask

    task automatic test_unbroken_stream();
        idling_on = 1'b0;
        repeat (150)
            offer_random_edit(48);
        idling_on = 1'b1;
    endtask

    // The receiver stops taking results for a long stretch while items keep coming.
    task automatic test_output_hold_off();
        hold_off_request = 1'b1;
        repeat (40)
            offer_random_edit(32);
    endtask

    always @(posedge clk)
    begin : reply_sink
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(idling_on && $urandom_range(0, 99) < STALL_PERCENT);
        end
    end

    always @(posedge clk)
    begin : reply_checker
        store_reply_t want;
        if (m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result transfer with none awaited: char_out %0d text_length %0d status %0d",
                       m_tdata[7:0], m_tdata[20:8], m_tuser);
                fail_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (m_tdata[7:0] !== want.char_out)
                begin
                    $error("char_out: expected %0d, actual %0d", want.char_out, m_tdata[7:0]);
                    fail_count++;
                end
                if (m_tdata[20:8] !== want.text_length)
                begin
                    $error("text_length: expected %0d, actual %0d", want.text_length,
                           m_tdata[20:8]);
                    fail_count++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        shadow_gap_first = 0;
        shadow_gap_after = CAPACITY;
        foreach (shadow_text[i])
            shadow_text[i] = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_editing();
        test_unbroken_stream();
        test_output_hold_off();

        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
